@@ sv/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the CRC byte update for the reply frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  STATUS_OK     = 8'h01;
  localparam logic [3:0]  PAYLOAD_START = 4'd6;
  localparam logic [3:0]  COUNT_SAT     = 4'd9;
  localparam logic [3:0]  PAYLOAD_IDX   = PAYLOAD_START + 4'd3;
  localparam logic [3:0]  CRC_START     = 4'd2;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_SUCCESS = 2'd0,
    VERDICT_FAIL    = 2'd1,
    VERDICT_TIMEOUT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_verd;
    verdict_t   verd;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/rfc_in_if.sv @@
// ----------------------------------------------------------------------------
// rfc_in_if
// Input channel: one received reply byte per item with its end-of-frame flag.
// ----------------------------------------------------------------------------
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

@@ sv/rfc_out_if.sv @@
// ----------------------------------------------------------------------------
// rfc_out_if
// Result channel: payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [1:0] verdict;
  logic       end_of_run;

  modport source (output valid, output kind, output payload_byte, output verdict,
                  output end_of_run, input ready);
  modport sink (input valid, input kind, input payload_byte, input verdict,
                input end_of_run, output ready);
endinterface

@@ sv/rfc_front.sv @@
// ----------------------------------------------------------------------------
// rfc_front
// Accepts bytes, runs the CRC and trailer delay line, and queues result jobs.
// ----------------------------------------------------------------------------
module rfc_front
  import rfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rfc_in_if.sink    in_ch,
  input  logic      q_full,
  output q_push_t   push
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  dly_r [3];
  logic [7:0]  dly_nxt [3];
  logic [3:0]  cnt_r, cnt_nxt;
  logic        fwz_r, fwz_nxt;

  logic        accept;
  logic        fwz_cur;
  logic [15:0] crc_upd;
  logic        has_pay;
  verdict_t    verd;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;

  always_comb begin
    fwz_cur = (cnt_r == 4'd0) ? (in_ch.rx_byte == 8'h00) : fwz_r;
    crc_upd = (cnt_r >= CRC_START) ? crc16_byte(crc_r, dly_r[1]) : crc_r;
    has_pay = (cnt_r >= PAYLOAD_IDX);

    priority if (fwz_cur) begin
      verd = VERDICT_TIMEOUT;
    end else if (cnt_r < CRC_START) begin
      verd = VERDICT_FAIL;
    end else if (crc_upd[15:8] == dly_r[0] && crc_upd[7:0] == in_ch.rx_byte &&
                 dly_r[1] == STATUS_OK) begin
      verd = VERDICT_SUCCESS;
    end else begin
      verd = VERDICT_FAIL;
    end

    push.valid        = accept && (has_pay || in_ch.last_byte);
    push.job.has_pay  = has_pay;
    push.job.pay_byte = dly_r[2];
    push.job.has_verd = in_ch.last_byte;
    push.job.verd     = verd;

    crc_nxt    = crc_r;
    dly_nxt[0] = dly_r[0];
    dly_nxt[1] = dly_r[1];
    dly_nxt[2] = dly_r[2];
    cnt_nxt    = cnt_r;
    fwz_nxt    = fwz_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        crc_nxt    = CRC_INIT;
        dly_nxt[0] = 8'h00;
        dly_nxt[1] = 8'h00;
        dly_nxt[2] = 8'h00;
        cnt_nxt    = 4'd0;
        fwz_nxt    = 1'b0;
      end else begin
        crc_nxt    = crc_upd;
        dly_nxt[0] = in_ch.rx_byte;
        dly_nxt[1] = dly_r[0];
        dly_nxt[2] = dly_r[1];
        cnt_nxt    = (cnt_r < COUNT_SAT) ? cnt_r + 4'd1 : cnt_r;
        fwz_nxt    = fwz_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      dly_r[0] <= 8'h00;
      dly_r[1] <= 8'h00;
      dly_r[2] <= 8'h00;
      cnt_r    <= 4'd0;
      fwz_r    <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      dly_r[0] <= dly_nxt[0];
      dly_r[1] <= dly_nxt[1];
      dly_r[2] <= dly_nxt[2];
      cnt_r    <= cnt_nxt;
      fwz_r    <= fwz_nxt;
    end
  end

endmodule

@@ sv/rfc_queue.sv @@
// ----------------------------------------------------------------------------
// rfc_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module rfc_queue
  import rfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push.valid && !full;
    do_pop     = pop && head.valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/rfc_back.sv @@
// ----------------------------------------------------------------------------
// rfc_back
// Expands queued jobs into payload and verdict results behind an output register.
// ----------------------------------------------------------------------------
module rfc_back
  import rfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  rfc_out_if.source out_ch
);

  logic       valid_r, valid_nxt;
  logic       phase_r, phase_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] pay_r, pay_nxt;
  verdict_t   verd_r, verd_nxt;
  logic       eor_r, eor_nxt;
  logic       load;

  always_comb begin
    load      = !valid_r || out_ch.ready;
    pop       = 1'b0;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    pay_nxt   = pay_r;
    verd_nxt  = verd_r;
    eor_nxt   = eor_r;
    if (load) begin
      valid_nxt = head.valid;
      if (head.valid) begin
        if (head.job.has_pay && !phase_r) begin
          kind_nxt = KIND_PAYLOAD;
          pay_nxt  = head.job.pay_byte;
          verd_nxt = VERDICT_SUCCESS;
          eor_nxt  = !head.job.has_verd;
          if (head.job.has_verd) begin
            phase_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          kind_nxt  = KIND_VERDICT;
          pay_nxt   = 8'h00;
          verd_nxt  = head.job.verd;
          eor_nxt   = 1'b1;
          pop       = 1'b1;
          phase_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pay_r  <= pay_nxt;
    verd_r <= verd_nxt;
    eor_r  <= eor_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = pay_r;
  assign out_ch.verdict      = verd_r;
  assign out_ch.end_of_run   = eor_r;

endmodule

@@ sv/reply_frame_checker_core.sv @@
// ----------------------------------------------------------------------------
// reply_frame_checker_core
// Streaming CRC-16/CCITT-FALSE checker for reply frames, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its four-entry job queue has room.
// Payload bytes come out three bytes behind the input, and the frame verdict
// (success, fail or timeout) follows the last payload byte. Results pass
// through the job queue and then an output register. The output port gives
// one result per cycle while the receiver is ready, so the final byte of
// a frame with payload yields two results, a payload byte and the verdict;
// this single result port sets the sustained rate, which is one byte per
// cycle apart from the extra result per frame.
module reply_frame_checker_core
  import rfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rfc_in_if.sink    in_ch,
  rfc_out_if.source out_ch
);

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  rfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  rfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  rfc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
